// ===== hw/rtl/roi_max_pool_bin_assert.svh =====
// Assertion macros shared by the RTL of the ROI max pooling block
`ifndef ROI_MAX_POOL_BIN_ASSERT_SVH
`define ROI_MAX_POOL_BIN_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define RMPB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rmpb assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define RMPB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rmpb assertion failed");

`endif

// ===== hw/rtl/rmpb_pkg.sv =====
// Package: types, constants and codes of the ROI max pooling block
package rmpb_pkg;

	localparam int DEF_MAX_BATCHES  = 2;
	localparam int DEF_MAX_CHANNELS = 16;
	localparam int DEF_MAX_HEIGHT   = 32;
	localparam int DEF_MAX_WIDTH    = 32;
	localparam int DEF_MAX_POOLED   = 16;

	localparam int CORNER_W = 22;                    // scaled corner, signed
	localparam int SIZE_W   = CORNER_W + 1;          // region width or height
	localparam int POOL_W   = 5;                     // pooled count register
	localparam int NUM_W    = POOL_W + SIZE_W + 1;   // edge dividend
	localparam int CFG_AW   = 3;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_BAD_BATCH = 2'd2,
		STAT_RANGE     = 2'd3
	} rmpb_status_t;

	typedef enum logic [CFG_AW-1:0] {
		CFG_BATCH_COUNT   = 3'd0,
		CFG_CHANNEL_COUNT = 3'd1,
		CFG_MAP_HEIGHT    = 3'd2,
		CFG_MAP_WIDTH     = 3'd3,
		CFG_POOLED_ROWS   = 3'd4,
		CFG_POOLED_COLS   = 3'd5,
		CFG_COORD_SCALE   = 3'd6
	} rmpb_cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_RND,
		ST_SIZE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EDGE,
		ST_TEST,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} rmpb_state_t;

	typedef struct packed {
		logic [1:0]  batch_count;
		logic [4:0]  channel_count;
		logic [5:0]  map_height;
		logic [5:0]  map_width;
		logic [4:0]  pooled_rows;
		logic [4:0]  pooled_cols;
		logic [15:0] coord_scale;
	} rmpb_cfg_t;

	typedef struct packed {
		logic              kind;
		logic [7:0]        batch_index;
		logic [3:0]        channel;
		logic [4:0]        row;
		logic [4:0]        col;
		logic signed [15:0] value;
		logic signed [15:0] roi_x1;
		logic signed [15:0] roi_y1;
		logic signed [15:0] roi_x2;
		logic signed [15:0] roi_y2;
		logic [3:0]        bin_row;
		logic [3:0]        bin_col;
	} rmpb_req_t;

	typedef struct packed {
		logic       store;
		logic       capture;
		logic       stat_load;
		logic       mul;
		logic       rnd;
		logic [1:0] sel;
		logic       size;
		logic       div_start;
		logic       edge_load;
		logic       empty_load;
		logic       scan_init;
		logic       scan_step;
		logic       out_load;
	} rmpb_cmd_t;

	typedef struct packed {
		logic query_bad;
		logic bin_empty;
		logic div_done;
		logic scan_last;
		logic out_free;
	} rmpb_stat_t;

endpackage

// ===== hw/rtl/rmpb_in_if.sv =====
// Request channel: one load or one query per transaction
interface rmpb_in_if;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [7:0]        batch_index;
	logic [3:0]        channel;
	logic [4:0]        row;
	logic [4:0]        col;
	logic signed [15:0] value;
	logic signed [15:0] roi_x1;
	logic signed [15:0] roi_y1;
	logic signed [15:0] roi_x2;
	logic signed [15:0] roi_y2;
	logic [3:0]        bin_row;
	logic [3:0]        bin_col;

	modport source (output valid, kind, batch_index, channel, row, col, value,
		roi_x1, roi_y1, roi_x2, roi_y2, bin_row, bin_col, input ready);
	modport sink (input valid, kind, batch_index, channel, row, col, value,
		roi_x1, roi_y1, roi_x2, roi_y2, bin_row, bin_col, output ready);
endinterface

// ===== hw/rtl/rmpb_out_if.sv =====
// Result channel: one bin maximum and status per transaction
interface rmpb_out_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] max_value;
	logic [1:0]        status;

	modport source (output valid, max_value, status, input ready);
	modport sink (input valid, max_value, status, output ready);
endinterface

// ===== hw/rtl/rmpb_cfg_if.sv =====
// Configuration write channel: register index and data
interface rmpb_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [rmpb_pkg::CFG_AW-1:0]  addr;
	logic [15:0]                  data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// ===== hw/rtl/roi_max_pool_bin.sv =====
// Load: one element per cycle while no query is in progress; an in-range element is
// written to the feature store at acceptance. Query: a flagged request goes straight
// to the result; otherwise the corners are scaled, the bit-serial edge divider finds
// the four bin edges, and a one-read-per-cycle scan reads the bin unless it is empty.
// The result waits while the result register is full. Reset (arst_n low) clears
// control state and restores the register defaults; the feature store is not cleared.
module roi_max_pool_bin #(
	parameter int MAX_BATCHES  = rmpb_pkg::DEF_MAX_BATCHES,
	parameter int MAX_CHANNELS = rmpb_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_HEIGHT   = rmpb_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH    = rmpb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_POOLED   = rmpb_pkg::DEF_MAX_POOLED
) (
	input logic          clk,
	input logic          arst_n,
	rmpb_in_if.sink      req,
	rmpb_out_if.source   rsp,
	rmpb_cfg_if.sink     cfg
);
	rmpb_pkg::rmpb_cfg_t  cfg_q;
	rmpb_pkg::rmpb_req_t  req_fields;
	rmpb_pkg::rmpb_cmd_t  cmd;
	rmpb_pkg::rmpb_stat_t st;

	// Configuration writes land at once; the port never stalls.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.batch_count   <= 2'd1;
			cfg_q.channel_count <= 5'd16;
			cfg_q.map_height    <= 6'd32;
			cfg_q.map_width     <= 6'd32;
			cfg_q.pooled_rows   <= 5'd7;
			cfg_q.pooled_cols   <= 5'd7;
			cfg_q.coord_scale   <= 16'd4096;
		end else if (cfg.valid) begin
			// drop writes to indexes beyond the register list
			unique case (cfg.addr)
				rmpb_pkg::CFG_BATCH_COUNT:   cfg_q.batch_count   <= cfg.data[1:0];
				rmpb_pkg::CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg.data[4:0];
				rmpb_pkg::CFG_MAP_HEIGHT:    cfg_q.map_height    <= cfg.data[5:0];
				rmpb_pkg::CFG_MAP_WIDTH:     cfg_q.map_width     <= cfg.data[5:0];
				rmpb_pkg::CFG_POOLED_ROWS:   cfg_q.pooled_rows   <= cfg.data[4:0];
				rmpb_pkg::CFG_POOLED_COLS:   cfg_q.pooled_cols   <= cfg.data[4:0];
				rmpb_pkg::CFG_COORD_SCALE:   cfg_q.coord_scale   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Gather the request payload for the datapath.
	assign req_fields.kind        = req.kind;
	assign req_fields.batch_index = req.batch_index;
	assign req_fields.channel     = req.channel;
	assign req_fields.row         = req.row;
	assign req_fields.col         = req.col;
	assign req_fields.value       = req.value;
	assign req_fields.roi_x1      = req.roi_x1;
	assign req_fields.roi_y1      = req.roi_y1;
	assign req_fields.roi_x2      = req.roi_x2;
	assign req_fields.roi_y2      = req.roi_y2;
	assign req_fields.bin_row     = req.bin_row;
	assign req_fields.bin_col     = req.bin_col;

	// Sequencer: takes a request transaction only between queries; loads
	// complete in the accepting cycle, queries walk scale, edge and scan steps.
	rmpb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.kind),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath: store, arithmetic and the result register, which holds a
	// finished transaction while loads and the next query proceed.
	rmpb_datapath #(
		.MAX_BATCHES  (MAX_BATCHES),
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_POOLED   (MAX_POOLED)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg           (cfg_q),
		.req           (req_fields),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.rsp_max_value (rsp.max_value),
		.rsp_status    (rsp.status)
	);
endmodule

// ===== hw/rtl/rmpb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
module rmpb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== hw/rtl/rmpb_div.sv =====
// Restoring divider, one quotient bit per cycle
module rmpb_div #(
	parameter int NW = rmpb_pkg::NUM_W,
	parameter int DW = rmpb_pkg::POOL_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quot,
	output logic          done
);
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic          ge;

	assign rem_sh = {rem_q, quo_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign quot = quo_q;
	assign done = done_q;
endmodule

// ===== hw/rtl/rmpb_ctrl.sv =====
// Query sequencer of the ROI max pooling block
module rmpb_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic                   req_kind,
	output logic                   req_ready,
	input  rmpb_pkg::rmpb_stat_t   st,
	output rmpb_pkg::rmpb_cmd_t    cmd
);
	`include "roi_max_pool_bin_assert.svh"

	rmpb_pkg::rmpb_state_t state_q, state_nxt;
	logic [1:0] idx_q;
	logic       idx_clr, idx_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmpb_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.sel   = idx_q;
		idx_clr   = 1'b0;
		idx_inc   = 1'b0;
		req_ready = 1'b0;
		unique case (state_q)
			rmpb_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid && !req_kind) begin
					cmd.store = 1'b1;
				end else if (req_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = rmpb_pkg::ST_CHECK;
				end
			end
			rmpb_pkg::ST_CHECK: begin
				cmd.stat_load = 1'b1;
				idx_clr       = 1'b1;
				state_nxt     = st.query_bad ? rmpb_pkg::ST_DONE : rmpb_pkg::ST_MUL;
			end
			rmpb_pkg::ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = rmpb_pkg::ST_RND;
			end
			rmpb_pkg::ST_RND: begin
				cmd.rnd = 1'b1;
				if (idx_q == 2'd3) begin
					idx_clr   = 1'b1;
					state_nxt = rmpb_pkg::ST_SIZE;
				end else begin
					idx_inc   = 1'b1;
					state_nxt = rmpb_pkg::ST_MUL;
				end
			end
			rmpb_pkg::ST_SIZE: begin
				cmd.size  = 1'b1;
				state_nxt = rmpb_pkg::ST_DIV_GO;
			end
			rmpb_pkg::ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_nxt     = rmpb_pkg::ST_DIV_WAIT;
			end
			rmpb_pkg::ST_DIV_WAIT: begin
				if (st.div_done) begin
					state_nxt = rmpb_pkg::ST_EDGE;
				end
			end
			rmpb_pkg::ST_EDGE: begin
				cmd.edge_load = 1'b1;
				if (idx_q == 2'd3) begin
					idx_clr   = 1'b1;
					state_nxt = rmpb_pkg::ST_TEST;
				end else begin
					idx_inc   = 1'b1;
					state_nxt = rmpb_pkg::ST_DIV_GO;
				end
			end
			rmpb_pkg::ST_TEST: begin
				cmd.empty_load = 1'b1;
				if (st.bin_empty) begin
					state_nxt = rmpb_pkg::ST_DONE;
				end else begin
					cmd.scan_init = 1'b1;
					state_nxt     = rmpb_pkg::ST_SCAN;
				end
			end
			rmpb_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_last) begin
					state_nxt = rmpb_pkg::ST_DRAIN;
				end
			end
			rmpb_pkg::ST_DRAIN: begin
				state_nxt = rmpb_pkg::ST_DONE;
			end
			rmpb_pkg::ST_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = rmpb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = rmpb_pkg::ST_IDLE;
			end
		endcase
	end

	`RMPB_ASSERT_IMP(a_out_room, clk, arst_n, cmd.out_load, st.out_free)
	`RMPB_ASSERT_NXT(a_div_multi, clk, arst_n, cmd.div_start, !st.div_done)
	`RMPB_ASSERT_IMP(a_scan_ok, clk, arst_n, cmd.scan_step, !st.query_bad)
endmodule

// ===== hw/rtl/rmpb_datapath.sv =====
// Datapath: feature store, corner scaling, bin edges, max scan, result register
module rmpb_datapath #(
	parameter int MAX_BATCHES  = rmpb_pkg::DEF_MAX_BATCHES,
	parameter int MAX_CHANNELS = rmpb_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_HEIGHT   = rmpb_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH    = rmpb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_POOLED   = rmpb_pkg::DEF_MAX_POOLED
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rmpb_pkg::rmpb_cmd_t   cmd,
	output rmpb_pkg::rmpb_stat_t  st,
	input  rmpb_pkg::rmpb_cfg_t   cfg,
	input  rmpb_pkg::rmpb_req_t   req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic signed [15:0]    rsp_max_value,
	output logic [1:0]            rsp_status
);
	`include "roi_max_pool_bin_assert.svh"

	localparam int DEPTH = MAX_BATCHES * MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int LW    = HW > WW ? HW : WW;
	localparam int CW    = rmpb_pkg::CORNER_W;
	localparam int SW    = rmpb_pkg::SIZE_W;
	localparam int PW    = rmpb_pkg::POOL_W;
	localparam int NW    = rmpb_pkg::NUM_W;
	localparam int EW    = NW + 2;

	function automatic logic [AW-1:0] addr_of(int b, int c, int h, int w);
		int a;
		begin
			a = ((b * MAX_CHANNELS + c) * MAX_HEIGHT + h) * MAX_WIDTH + w;
			return AW'(a);
		end
	endfunction

	rmpb_pkg::rmpb_req_t req_q;
	logic signed [32:0]  prod_q;
	logic signed [CW-1:0] crn_q [4];
	logic [SW-1:0]       rw_q, rh_q;
	logic [HW-1:0]       hs_q, he_q, h_q;
	logic [WW-1:0]       ws_q, we_q, w_q;
	logic [1:0]          stat_q;
	logic                first_q, rd_valid_s1;
	logic signed [15:0]  max_q;
	logic                rsp_valid_q;
	logic signed [15:0]  rsp_max_q;
	logic [1:0]          rsp_stat_q;

	// clamped configuration
	logic [PW-1:0] pr, pc;
	logic [HW-1:0] lim_h;
	logic [WW-1:0] lim_w;

	assign pr    = (32'(cfg.pooled_rows) > MAX_POOLED) ? PW'(MAX_POOLED) : cfg.pooled_rows;
	assign pc    = (32'(cfg.pooled_cols) > MAX_POOLED) ? PW'(MAX_POOLED) : cfg.pooled_cols;
	assign lim_h = (32'(cfg.map_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg.map_height);
	assign lim_w = (32'(cfg.map_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg.map_width);

	// query checks
	logic       bad_batch, bad_range;
	logic [1:0] qstat;

	assign bad_batch = (32'(req_q.batch_index) >= 32'(cfg.batch_count))
		|| (32'(req_q.batch_index) >= MAX_BATCHES);
	assign bad_range = (32'(req_q.channel) >= 32'(cfg.channel_count))
		|| (32'(req_q.channel) >= MAX_CHANNELS)
		|| (32'(req_q.bin_row) >= 32'(cfg.pooled_rows)) || (32'(req_q.bin_row) >= MAX_POOLED)
		|| (32'(req_q.bin_col) >= 32'(cfg.pooled_cols)) || (32'(req_q.bin_col) >= MAX_POOLED);
	assign qstat = bad_batch ? rmpb_pkg::STAT_BAD_BATCH
		: (bad_range ? rmpb_pkg::STAT_RANGE : rmpb_pkg::STAT_OK);

	// feature store
	logic           ld_ok;
	logic [15:0]    rdata;

	assign ld_ok = (32'(req.batch_index) < MAX_BATCHES) && (32'(req.channel) < MAX_CHANNELS)
		&& (32'(req.row) < MAX_HEIGHT) && (32'(req.col) < MAX_WIDTH);

	rmpb_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (cmd.store && ld_ok),
		.waddr (addr_of(int'(req.batch_index), int'(req.channel), int'(req.row),
			int'(req.col))),
		.wdata (req.value),
		.re    (cmd.scan_step),
		.raddr (addr_of(int'(req_q.batch_index), int'(req_q.channel), int'(h_q), int'(w_q))),
		.rdata (rdata)
	);

	// corner scaling
	logic signed [15:0]   corner;
	logic signed [20:0]   flr;
	logic [11:0]          frac;
	logic                 up;
	logic signed [CW-1:0] rounded;

	always_comb begin
		case (cmd.sel)
			2'd0:    corner = req_q.roi_x1;
			2'd1:    corner = req_q.roi_y1;
			2'd2:    corner = req_q.roi_x2;
			default: corner = req_q.roi_y2;
		endcase
	end

	assign flr     = prod_q[32:12];
	assign frac    = prod_q[11:0];
	assign up      = (frac > 12'd2048) || ((frac == 12'd2048) && flr[0]);
	assign rounded = CW'(flr) + CW'(up);

	// region size
	logic signed [CW:0] dx, dy;
	assign dx = (CW + 1)'(crn_q[2]) - (CW + 1)'(crn_q[0]) + (CW + 1)'(1);
	assign dy = (CW + 1)'(crn_q[3]) - (CW + 1)'(crn_q[1]) + (CW + 1)'(1);

	// edge dividend
	logic [PW-1:0] fb, pool;
	logic [SW-1:0] sz;
	logic [NW-1:0] prodn, num, quot;
	logic          div_done;

	assign pool  = cmd.sel[1] ? pc : pr;
	assign sz    = cmd.sel[1] ? rw_q : rh_q;
	assign fb    = (cmd.sel[1] ? {1'b0, req_q.bin_col} : {1'b0, req_q.bin_row})
		+ PW'(cmd.sel[0]);
	assign prodn = NW'(fb) * NW'(sz);
	assign num   = cmd.sel[0] ? prodn + NW'(pool) - NW'(1) : prodn;

	rmpb_div #(.NW(NW), .DW(PW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (pool),
		.quot   (quot),
		.done   (div_done)
	);

	// edge offset and clamp
	logic signed [EW-1:0] edge_sum, lim_s, edge_cl;
	assign edge_sum = $signed({2'b00, quot}) + EW'(cmd.sel[1] ? crn_q[0] : crn_q[1]);
	assign lim_s    = $signed(EW'(cmd.sel[1] ? LW'(lim_w) : LW'(lim_h)));
	assign edge_cl  = (edge_sum < 0) ? '0 : ((edge_sum > lim_s) ? lim_s : edge_sum);

	logic w_end;
	assign w_end = (w_q == WW'(we_q - WW'(1)));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.mul) begin
			prod_q <= corner * $signed({1'b0, cfg.coord_scale});
		end
		if (cmd.rnd) begin
			crn_q[cmd.sel] <= rounded;
		end
		if (cmd.size) begin
			rw_q <= (dx < 1) ? SW'(1) : SW'(dx);
			rh_q <= (dy < 1) ? SW'(1) : SW'(dy);
		end
		if (cmd.edge_load) begin
			case (cmd.sel)
				2'd0:    hs_q <= HW'(edge_cl);
				2'd1:    he_q <= HW'(edge_cl);
				2'd2:    ws_q <= WW'(edge_cl);
				default: we_q <= WW'(edge_cl);
			endcase
		end
		if (cmd.scan_init) begin
			h_q <= hs_q;
			w_q <= ws_q;
		end else if (cmd.scan_step) begin
			if (w_end) begin
				w_q <= ws_q;
				h_q <= h_q + HW'(1);
			end else begin
				w_q <= w_q + WW'(1);
			end
		end
		if (cmd.stat_load) begin
			stat_q <= qstat;
		end else if (cmd.empty_load) begin
			stat_q <= st.bin_empty ? rmpb_pkg::STAT_EMPTY : rmpb_pkg::STAT_OK;
		end
		if (rd_valid_s1 && (first_q || $signed(rdata) > max_q)) begin
			max_q <= $signed(rdata);
		end
		if (cmd.out_load) begin
			rsp_stat_q <= stat_q;
			rsp_max_q  <= (stat_q == rmpb_pkg::STAT_OK) ? max_q : 16'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_step;
			if (cmd.scan_init) begin
				first_q <= 1'b1;
			end else if (rd_valid_s1) begin
				first_q <= 1'b0;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign st.query_bad = (qstat != rmpb_pkg::STAT_OK);
	assign st.bin_empty = !((he_q > hs_q) && (we_q > ws_q));
	assign st.div_done  = div_done;
	assign st.scan_last = (h_q == HW'(he_q - HW'(1))) && w_end;
	assign st.out_free  = !rsp_valid_q || rsp_ready;

	assign rsp_valid     = rsp_valid_q;
	assign rsp_max_value = rsp_max_q;
	assign rsp_status    = rsp_stat_q;

	`RMPB_ASSERT_IMP(a_scan_bounds, clk, arst_n, cmd.scan_step,
		(h_q < he_q) && (h_q >= hs_q) && (w_q < we_q) && (w_q >= ws_q))
	`RMPB_ASSERT_IMP(a_flag_zero, clk, arst_n,
		rsp_valid_q && (rsp_stat_q != rmpb_pkg::STAT_OK), rsp_max_q == 16'sd0)
endmodule

// ===== test/roi_max_pool_bin_test_ifs.sv =====
// Stimulus table row type of the ROI max pooling testbench
`timescale 1ns / 100ps
package rmpb_test_pkg;

	// one row of the directed table; chk says whether exp_* is typed in
	typedef struct {
		rmpb_pkg::rmpb_req_t    req;
		logic                   chk;
		logic [15:0]            exp_max;
		rmpb_pkg::rmpb_status_t exp_stat;
	} rmpb_row_t;
endpackage

// ===== test/roi_max_pool_bin_test.sv =====
// Testbench for the ROI max pooling block: directed table plus random loads and queries
`timescale 1ns / 100ps
module roi_max_pool_bin_test;

	localparam int NB = rmpb_pkg::DEF_MAX_BATCHES;
	localparam int NCH = rmpb_pkg::DEF_MAX_CHANNELS;
	localparam int MH = rmpb_pkg::DEF_MAX_HEIGHT;
	localparam int MW = rmpb_pkg::DEF_MAX_WIDTH;
	localparam int MP = rmpb_pkg::DEF_MAX_POOLED;
	localparam int PATCH_C = 2;
	localparam int PATCH_H = 8;
	localparam int PATCH_W = 8;
	localparam int LIMIT = 3000000;

	logic clk;
	logic arst_n;

	rmpb_in_if  req();
	rmpb_out_if rsp();
	rmpb_cfg_if cfg();

	roi_max_pool_bin DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	// shadow of the feature map and the register file
	logic [15:0]         fmap [NB][NCH][MH][MW];
	bit                  fmap_set [NB][NCH][MH][MW];
	rmpb_pkg::rmpb_cfg_t regs;

	typedef struct {
		logic [15:0]            maxv;
		rmpb_pkg::rmpb_status_t stat;
	} bin_result_t;

	bin_result_t pending_bins[$];

	int errors;
	int cycles;
	int src_idle_pct;
	int snk_stall_pct;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic longint scale_q412(logic signed [15:0] raw);
		longint p, q, r;
		p = longint'(raw) * longint'(regs.coord_scale);
		q = p / 4096;
		r = p - q * 4096;
		if (r < 0) begin
			q -= 1;
			r += 4096;
		end
		// round half to even
		if (r > 2048 || (r == 2048 && q[0]))
			q += 1;
		return q;
	endfunction

	function automatic longint clip(longint v, longint hi);
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int umin(int v, int hi);
		return v > hi ? hi : v;
	endfunction

	// bin edges of a query, clamped to the map
	function automatic void bin_edges(rmpb_pkg::rmpb_req_t q, output longint hs,
			output longint he, output longint ws, output longint we);
		longint x1, y1, x2, y2, rw, rh, pr, pc, lh, lw;
		x1 = scale_q412(q.roi_x1);
		y1 = scale_q412(q.roi_y1);
		x2 = scale_q412(q.roi_x2);
		y2 = scale_q412(q.roi_y2);
		rw = x2 - x1 + 1;
		rh = y2 - y1 + 1;
		if (rw < 1) rw = 1;
		if (rh < 1) rh = 1;
		pr = longint'(umin(int'(regs.pooled_rows), MP));
		pc = longint'(umin(int'(regs.pooled_cols), MP));
		lh = longint'(umin(int'(regs.map_height), MH));
		lw = longint'(umin(int'(regs.map_width), MW));
		hs = clip(longint'(q.bin_row) * rh / pr + y1, lh);
		he = clip(((longint'(q.bin_row) + 1) * rh + pr - 1) / pr + y1, lh);
		ws = clip(longint'(q.bin_col) * rw / pc + x1, lw);
		we = clip(((longint'(q.bin_col) + 1) * rw + pc - 1) / pc + x1, lw);
	endfunction

	function automatic rmpb_pkg::rmpb_status_t query_flag(rmpb_pkg::rmpb_req_t q);
		if (int'(q.batch_index) >= umin(int'(regs.batch_count), NB))
			return rmpb_pkg::STAT_BAD_BATCH;
		if (int'(q.channel) >= umin(int'(regs.channel_count), NCH)
				|| int'(q.bin_row) >= umin(int'(regs.pooled_rows), MP)
				|| int'(q.bin_col) >= umin(int'(regs.pooled_cols), MP))
			return rmpb_pkg::STAT_RANGE;
		return rmpb_pkg::STAT_OK;
	endfunction

	// predict the bin maximum; the stimulus never lets it touch unwritten entries
	function automatic bin_result_t pool_bin(rmpb_pkg::rmpb_req_t q);
		bin_result_t res;
		longint hs, he, ws, we;
		logic signed [15:0] v;
		res.maxv = '0;
		res.stat = query_flag(q);
		if (res.stat != rmpb_pkg::STAT_OK) return res;
		bin_edges(q, hs, he, ws, we);
		if (!(he > hs && we > ws)) begin
			res.stat = rmpb_pkg::STAT_EMPTY;
			return res;
		end
		for (longint h = hs; h < he; h++)
			for (longint w = ws; w < we; w++) begin
				v = fmap[q.batch_index][q.channel][h][w];
				if ((h == hs && w == ws) || v > $signed(res.maxv)) res.maxv = v;
			end
		return res;
	endfunction

	// true when the query is legal: no scanned entry left unwritten
	function automatic bit reads_written(rmpb_pkg::rmpb_req_t q);
		longint hs, he, ws, we;
		if (query_flag(q) != rmpb_pkg::STAT_OK) return 1;
		bin_edges(q, hs, he, ws, we);
		for (longint h = hs; h < he; h++)
			for (longint w = ws; w < we; w++)
				if (!fmap_set[q.batch_index][q.channel][h][w]) return 0;
		return 1;
	endfunction

	// hold the request until accepted, with random gaps before it; valid stays
	// high on return so back-to-back items need no gap
	task automatic send_item(rmpb_pkg::rmpb_req_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= it.kind;
		req.batch_index <= it.batch_index;
		req.channel <= it.channel;
		req.row <= it.row;
		req.col <= it.col;
		req.value <= it.value;
		req.roi_x1 <= it.roi_x1;
		req.roi_y1 <= it.roi_y1;
		req.roi_x2 <= it.roi_x2;
		req.roi_y2 <= it.roi_y2;
		req.bin_row <= it.bin_row;
		req.bin_col <= it.bin_col;
		do @(posedge clk); while (!req.ready);
		// this transaction is now taken; update the shadow store
		if (!it.kind) begin
			if (int'(it.batch_index) < NB) begin
				fmap[it.batch_index][it.channel][it.row][it.col] = it.value;
				fmap_set[it.batch_index][it.channel][it.row][it.col] = 1;
			end
		end else
			pending_bins.push_back(pool_bin(it));
	endtask

	// drop valid, drain the results, then idle before touching registers
	task automatic settle();
		req.valid <= 1'b0;
		while (pending_bins.size() != 0) @(posedge clk);
		repeat (1500) @(posedge clk);
	endtask

	task automatic write_reg(rmpb_pkg::rmpb_cfg_idx_t idx, logic [15:0] d);
		cfg.valid <= 1'b1;
		cfg.addr <= idx;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			rmpb_pkg::CFG_BATCH_COUNT:   regs.batch_count = d[1:0];
			rmpb_pkg::CFG_CHANNEL_COUNT: regs.channel_count = d[4:0];
			rmpb_pkg::CFG_MAP_HEIGHT:    regs.map_height = d[5:0];
			rmpb_pkg::CFG_MAP_WIDTH:     regs.map_width = d[5:0];
			rmpb_pkg::CFG_POOLED_ROWS:   regs.pooled_rows = d[4:0];
			rmpb_pkg::CFG_POOLED_COLS:   regs.pooled_cols = d[4:0];
			rmpb_pkg::CFG_COORD_SCALE:   regs.coord_scale = d;
			default: ;
		endcase
	endtask

	function automatic rmpb_pkg::rmpb_req_t load_item(int b, int c, int h, int w,
			logic [15:0] v);
		rmpb_pkg::rmpb_req_t it;
		it = '0;
		it.batch_index = 8'(b);
		it.channel = 4'(c);
		it.row = 5'(h);
		it.col = 5'(w);
		it.value = v;
		return it;
	endfunction

	function automatic rmpb_pkg::rmpb_req_t query_item(int b, int c, int x1, int y1, int x2,
			int y2, int br, int bc);
		rmpb_pkg::rmpb_req_t it;
		it = '0;
		it.kind = 1'b1;
		it.batch_index = 8'(b);
		it.channel = 4'(c);
		it.roi_x1 = 16'(x1);
		it.roi_y1 = 16'(y1);
		it.roi_x2 = 16'(x2);
		it.roi_y2 = 16'(y2);
		it.bin_row = 4'(br);
		it.bin_col = 4'(bc);
		return it;
	endfunction

	// random query mostly over the loaded patch; full-range corners now and then
	function automatic rmpb_pkg::rmpb_req_t rand_query();
		rmpb_pkg::rmpb_req_t it;
		int x1, y1, b, c, npr, npc;
		x1 = int'($urandom_range(PATCH_W - 1));
		y1 = int'($urandom_range(PATCH_H - 1));
		b = ($urandom_range(9) == 0) ? int'($urandom_range(255)) : int'($urandom_range(NB - 1));
		c = ($urandom_range(3) == 0) ? int'($urandom_range(15))
			: int'($urandom_range(PATCH_C - 1));
		it = query_item(b, c, x1, y1, x1 + int'($urandom_range(PATCH_W + 1)) - 3,
			y1 + int'($urandom_range(PATCH_H + 1)) - 3,
			int'($urandom_range(15)), int'($urandom_range(15)));
		if ($urandom_range(7) == 0) begin
			it.roi_x1 = 16'($urandom);
			it.roi_y1 = 16'($urandom);
			it.roi_x2 = 16'($urandom);
			it.roi_y2 = 16'($urandom);
		end
		if ($urandom_range(3) != 0) begin
			npr = umin(int'(regs.pooled_rows), MP);
			npc = umin(int'(regs.pooled_cols), MP);
			it.bin_row = 4'($urandom_range(npr > 0 ? npr - 1 : 0));
			it.bin_col = 4'($urandom_range(npc > 0 ? npc - 1 : 0));
		end
		return it;
	endfunction

	// check results against the oldest prediction; stall the result channel at random
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b1;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_bins.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h/%0d", rsp.max_value, rsp.status);
				end else begin
					bin_result_t e;
					e = pending_bins.pop_front();
					if (rsp.max_value !== e.maxv || rsp.status !== e.stat) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %h/%0d got %h/%0d",
								e.maxv, e.stat, rsp.max_value, rsp.status);
					end
				end
			end
			rsp.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	rmpb_test_pkg::rmpb_row_t dir_rows[$];

	initial begin
		rmpb_pkg::rmpb_req_t it;
		int phase;
		errors = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.kind = 1'b0;
		req.batch_index = '0;
		req.channel = '0;
		req.row = '0;
		req.col = '0;
		req.value = '0;
		req.roi_x1 = '0;
		req.roi_y1 = '0;
		req.roi_x2 = '0;
		req.roi_y2 = '0;
		req.bin_row = '0;
		req.bin_col = '0;
		cfg.valid = 1'b0;
		cfg.addr = rmpb_pkg::CFG_BATCH_COUNT;
		cfg.data = '0;
		regs = '{2'd1, 5'd16, 6'd32, 6'd32, 5'd7, 5'd7, 16'd4096};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; rows with chk set carry the plainly readable answer
		dir_rows.push_back('{load_item(0, 0, 0, 0, 16'h7FFF), 1'b0, 16'h0000, rmpb_pkg::STAT_OK});
		dir_rows.push_back('{load_item(0, 0, 0, 1, 16'h8000), 1'b0, 16'h0000, rmpb_pkg::STAT_OK});
		dir_rows.push_back('{load_item(0, 0, 1, 0, 16'h0000), 1'b0, 16'h0000, rmpb_pkg::STAT_OK});
		dir_rows.push_back('{load_item(0, 0, 1, 1, 16'hFFFF), 1'b0, 16'h0000, rmpb_pkg::STAT_OK});
		dir_rows.push_back('{load_item(0, 15, 31, 31, 16'h1234), 1'b0, 16'h0000,
			rmpb_pkg::STAT_OK});
		dir_rows.push_back('{load_item(255, 15, 31, 31, 16'hAAAA), 1'b0, 16'h0000,
			rmpb_pkg::STAT_OK});
		// bad batch, checked first even with a bad bin
		dir_rows.push_back('{query_item(1, 0, 0, 0, 1, 1, 0, 0), 1'b1, 16'h0000,
			rmpb_pkg::STAT_BAD_BATCH});
		dir_rows.push_back('{query_item(255, 15, 0, 0, 1, 1, 15, 15), 1'b1, 16'h0000,
			rmpb_pkg::STAT_BAD_BATCH});
		// bin outside the 7x7 grid
		dir_rows.push_back('{query_item(0, 0, 0, 0, 1, 1, 7, 0), 1'b1, 16'h0000,
			rmpb_pkg::STAT_RANGE});
		dir_rows.push_back('{query_item(0, 0, 0, 0, 1, 1, 0, 15), 1'b1, 16'h0000,
			rmpb_pkg::STAT_RANGE});
		// region entirely off the map: empty bin
		dir_rows.push_back('{query_item(0, 0, -32768, -32768, -32768, -32768, 0, 0),
			1'b1, 16'h0000, rmpb_pkg::STAT_EMPTY});
		dir_rows.push_back('{query_item(0, 0, 32767, 32767, 32767, 32767, 6, 6), 1'b1, 16'h0000,
			rmpb_pkg::STAT_EMPTY});
		// single-element bins near the top-left corner and at the bottom-right corner
		dir_rows.push_back('{query_item(0, 0, 0, 0, 6, 6, 0, 0), 1'b1, 16'h7FFF,
			rmpb_pkg::STAT_OK});
		dir_rows.push_back('{query_item(0, 0, 0, 0, 1, 1, 0, 0), 1'b0, 16'h0000,
			rmpb_pkg::STAT_OK});
		dir_rows.push_back('{query_item(0, 0, 1, 1, 7, 7, 0, 0), 1'b1, 16'hFFFF,
			rmpb_pkg::STAT_OK});
		dir_rows.push_back('{query_item(0, 15, 31, 31, 31, 31, 6, 6), 1'b1, 16'h1234,
			rmpb_pkg::STAT_OK});

		foreach (dir_rows[i]) begin
			if (dir_rows[i].req.kind && !reads_written(dir_rows[i].req)) continue;
			if (dir_rows[i].chk && dir_rows[i].req.kind) begin
				bin_result_t p;
				p = pool_bin(dir_rows[i].req);
				if (p.maxv !== dir_rows[i].exp_max || p.stat !== dir_rows[i].exp_stat) begin
					errors++;
					if (errors <= 10) $display("table row %0d disagrees with prediction", i);
				end
			end
			send_item(dir_rows[i].req);
		end
		settle();

		// fully load a small patch so queries get past the store check
		for (int b = 0; b < NB; b++)
			for (int c = 0; c < PATCH_C; c++)
				for (int h = 0; h < PATCH_H; h++)
					for (int w = 0; w < PATCH_W; w++)
						if (!fmap_set[b][c][h][w])
							send_item(load_item(b, c, h, w, 16'($urandom)));
		settle();

		// random phases, each under its own register setting and one of four idling mixes
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 75; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 75; end
				default: begin src_idle_pct = 7; snk_stall_pct = 7; end
			endcase
			case (phase)
				0: ;
				1: begin
					write_reg(rmpb_pkg::CFG_BATCH_COUNT, 16'd2);
					write_reg(rmpb_pkg::CFG_POOLED_ROWS, 16'd1);
					write_reg(rmpb_pkg::CFG_POOLED_COLS, 16'd16);
					write_reg(rmpb_pkg::CFG_COORD_SCALE, 16'd2048);
				end
				2: begin
					write_reg(rmpb_pkg::CFG_CHANNEL_COUNT, 16'd1);
					write_reg(rmpb_pkg::CFG_MAP_HEIGHT, 16'd1);
					write_reg(rmpb_pkg::CFG_MAP_WIDTH, 16'd63);
					write_reg(rmpb_pkg::CFG_POOLED_ROWS, 16'd31);
					write_reg(rmpb_pkg::CFG_COORD_SCALE, 16'd6144);
				end
				3: begin
					write_reg(rmpb_pkg::CFG_BATCH_COUNT, 16'd3);
					write_reg(rmpb_pkg::CFG_CHANNEL_COUNT, 16'd31);
					write_reg(rmpb_pkg::CFG_MAP_HEIGHT, 16'd0);
					write_reg(rmpb_pkg::CFG_POOLED_COLS, 16'd0);
					write_reg(rmpb_pkg::CFG_COORD_SCALE, 16'd0);
				end
				4: begin
					write_reg(rmpb_pkg::CFG_MAP_HEIGHT, 16'd32);
					write_reg(rmpb_pkg::CFG_MAP_WIDTH, 16'd1);
					write_reg(rmpb_pkg::CFG_POOLED_ROWS, 16'd16);
					write_reg(rmpb_pkg::CFG_POOLED_COLS, 16'd3);
					write_reg(rmpb_pkg::CFG_COORD_SCALE, 16'hFFFF);
				end
				5: begin
					write_reg(rmpb_pkg::CFG_BATCH_COUNT, 16'd0);
					write_reg(rmpb_pkg::CFG_MAP_WIDTH, 16'd17);
					write_reg(rmpb_pkg::CFG_COORD_SCALE, 16'd6144);
				end
				6: begin
					write_reg(rmpb_pkg::CFG_BATCH_COUNT, 16'd1);
					write_reg(rmpb_pkg::CFG_CHANNEL_COUNT, 16'd16);
					write_reg(rmpb_pkg::CFG_POOLED_ROWS, 16'd5);
					write_reg(rmpb_pkg::CFG_POOLED_COLS, 16'd4);
					write_reg(rmpb_pkg::CFG_COORD_SCALE, 16'd1);
				end
				default: begin
					write_reg(rmpb_pkg::CFG_BATCH_COUNT, 16'd2);
					write_reg(rmpb_pkg::CFG_MAP_HEIGHT, 16'd32);
					write_reg(rmpb_pkg::CFG_MAP_WIDTH, 16'd32);
					write_reg(rmpb_pkg::CFG_POOLED_ROWS, 16'd7);
					write_reg(rmpb_pkg::CFG_POOLED_COLS, 16'd7);
					write_reg(rmpb_pkg::CFG_COORD_SCALE, 16'd4096);
				end
			endcase
			cfg.valid <= 1'b0;
			for (int n = 0; n < 55; n++) begin
				if ($urandom_range(1)) begin
					// loads fill the map; a few land out of range and are dropped
					it = load_item(($urandom_range(9) == 0) ? int'($urandom_range(255))
						: int'($urandom_range(NB - 1)), int'($urandom_range(15)),
						int'($urandom_range(31)), int'($urandom_range(31)), 16'($urandom));
					send_item(it);
				end else begin
					it = rand_query();
					if (reads_written(it)) send_item(it);
				end
			end
			settle();
		end

		if (errors == 0 && pending_bins.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ===== roi_max_pool_bin.f =====
+incdir+hw/rtl
hw/rtl/rmpb_pkg.sv
hw/rtl/rmpb_in_if.sv
hw/rtl/rmpb_out_if.sv
hw/rtl/rmpb_cfg_if.sv
hw/rtl/rmpb_ram.sv
hw/rtl/rmpb_div.sv
hw/rtl/rmpb_ctrl.sv
hw/rtl/rmpb_datapath.sv
hw/rtl/roi_max_pool_bin.sv
test/roi_max_pool_bin_test_ifs.sv
test/roi_max_pool_bin_test.sv
